// ===== sv/adex_pkg.sv =====
// package: types, constants and helper functions of the adex neuron step
package adex_pkg;

  localparam int unsigned DT_OVER_C_SHIFT_DEF   = 8;
  localparam int unsigned DT_OVER_TAU_SHIFT_DEF = 12;
  localparam int unsigned EXP_TABLE_BITS_DEF    = 8;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DIV_W  = 48;

  localparam logic signed [31:0] G_LEAK_RST  = 32'sd1966080;
  localparam logic signed [31:0] E_LEAK_RST  = -32'sd4626842;
  localparam logic        [30:0] SLOPE_RST   = 31'd131072;
  localparam logic signed [31:0] V_THRESH_RST = -32'sd3303014;
  localparam logic signed [31:0] ADAPT_A_RST = 32'sd262144;
  localparam logic signed [31:0] V_RESET_RST = -32'sd4626842;
  localparam logic signed [31:0] ADAPT_B_RST = 32'sd5275648;
  localparam logic signed [31:0] V_PEAK_RST  = 32'sd1310720;

  localparam logic [47:0] U_MAX_MAG = 48'd655360;
  localparam logic [47:0] U_MIN_MAG = 48'd786432;
  localparam logic signed [33:0] LOG2E_Q = 34'sd94548;

  localparam logic [2:0] REG_G_LEAK   = 3'd0;
  localparam logic [2:0] REG_E_LEAK   = 3'd1;
  localparam logic [2:0] REG_SLOPE    = 3'd2;
  localparam logic [2:0] REG_V_THRESH = 3'd3;
  localparam logic [2:0] REG_ADAPT_A  = 3'd4;
  localparam logic [2:0] REG_V_RESET  = 3'd5;
  localparam logic [2:0] REG_ADAPT_B  = 3'd6;
  localparam logic [2:0] REG_V_PEAK   = 3'd7;

  typedef struct packed {
    logic signed [31:0] g_leak;
    logic signed [31:0] e_leak;
    logic        [30:0] slope_factor;
    logic signed [31:0] v_thresh;
    logic signed [31:0] adapt_a;
    logic signed [31:0] v_reset;
    logic signed [31:0] adapt_b;
    logic signed [31:0] v_peak;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_LOG2E,
    OP_INTERP,
    OP_SHIFT,
    OP_MEXG,
    OP_MEXD,
    OP_MLEAK,
    OP_MADAPT,
    OP_UPDATE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic spike;
    logic out_free;
  } status_t;

  function automatic logic [17:0] pow2_poly(input logic [16:0] x);
    logic [63:0] t;
    t = 64'd5155;
    t = 64'd14822 + ((t * 64'(x)) >> 16);
    t = 64'd45559 + ((t * 64'(x)) >> 16);
    t = 64'd65536 + ((t * 64'(x)) >> 16);
    return t[17:0];
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p >>> 16;
    if (s > 68'sd2147483647) return 32'sh7fffffff;
    if (s < -68'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== sv/adex_in_if.sv =====
// input channel: one current sample per item
interface adex_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] injected_current;

  modport source (output valid, output injected_current, input ready);
  modport sink (input valid, input injected_current, output ready);
endinterface

// ===== sv/adex_out_if.sv =====
// output channel: membrane, adaptation and spike flag per item
interface adex_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] membrane_out;
  logic signed [31:0] adaptation_out;
  logic               spiked;

  modport source (output valid, output membrane_out, output adaptation_out, output spiked,
                  input ready);
  modport sink (input valid, input membrane_out, input adaptation_out, input spiked,
                output ready);
endinterface

// ===== sv/adex_regs.sv =====
// apb configuration register bank
module adex_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adex_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output adex_pkg::cfg_t                cfg_o
);
  import adex_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.g_leak       <= G_LEAK_RST;
      cfg_q.e_leak       <= E_LEAK_RST;
      cfg_q.slope_factor <= SLOPE_RST;
      cfg_q.v_thresh     <= V_THRESH_RST;
      cfg_q.adapt_a      <= ADAPT_A_RST;
      cfg_q.v_reset      <= V_RESET_RST;
      cfg_q.adapt_b      <= ADAPT_B_RST;
      cfg_q.v_peak       <= V_PEAK_RST;
    end else if (wr) begin
      case (idx)
        REG_G_LEAK:   cfg_q.g_leak       <= pwdata;
        REG_E_LEAK:   cfg_q.e_leak       <= pwdata;
        REG_SLOPE:    cfg_q.slope_factor <= pwdata[30:0];
        REG_V_THRESH: cfg_q.v_thresh     <= pwdata;
        REG_ADAPT_A:  cfg_q.adapt_a      <= pwdata;
        REG_V_RESET:  cfg_q.v_reset      <= pwdata;
        REG_ADAPT_B:  cfg_q.adapt_b      <= pwdata;
        REG_V_PEAK:   cfg_q.v_peak       <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_G_LEAK:   prdata = cfg_q.g_leak;
      REG_E_LEAK:   prdata = cfg_q.e_leak;
      REG_SLOPE:    prdata = {1'b0, cfg_q.slope_factor};
      REG_V_THRESH: prdata = cfg_q.v_thresh;
      REG_ADAPT_A:  prdata = cfg_q.adapt_a;
      REG_V_RESET:  prdata = cfg_q.v_reset;
      REG_ADAPT_B:  prdata = cfg_q.adapt_b;
      REG_V_PEAK:   prdata = cfg_q.v_peak;
      default:      prdata = '0;
    endcase
  end
endmodule

// ===== sv/adex_ctrl.sv =====
// sequencer for one euler tick
module adex_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  adex_pkg::status_t status_i,
  output adex_pkg::cmd_t    cmd_o
);
  import adex_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIV    = 10'b0000000010,
    S_EXP1   = 10'b0000000100,
    S_EXP2   = 10'b0000001000,
    S_EXP3   = 10'b0000010000,
    S_MEXG   = 10'b0000100000,
    S_MEXD   = 10'b0001000000,
    S_MLEAK  = 10'b0010000000,
    S_MADAPT = 10'b0100000000,
    S_UPD    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.spike) begin
          state_d = S_UPD;
        end else begin
          cmd_o.op = OP_DIV;
          if (status_i.div_done) state_d = S_EXP1;
        end
      end
      S_EXP1: begin
        cmd_o.op = OP_LOG2E;
        state_d  = S_EXP2;
      end
      S_EXP2: begin
        cmd_o.op = OP_INTERP;
        state_d  = S_EXP3;
      end
      S_EXP3: begin
        cmd_o.op = OP_SHIFT;
        state_d  = S_MEXG;
      end
      S_MEXG: begin
        cmd_o.op = OP_MEXG;
        state_d  = S_MEXD;
      end
      S_MEXD: begin
        cmd_o.op = OP_MEXD;
        state_d  = S_MLEAK;
      end
      S_MLEAK: begin
        cmd_o.op = OP_MLEAK;
        state_d  = S_MADAPT;
      end
      S_MADAPT: begin
        cmd_o.op = OP_MADAPT;
        state_d  = S_UPD;
      end
      S_UPD: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_UPDATE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== sv/adex_dp.sv =====
// datapath: state, divider, exponential table and shared multiplier
module adex_dp #(
  parameter int unsigned DT_OVER_C_SHIFT   = adex_pkg::DT_OVER_C_SHIFT_DEF,
  parameter int unsigned DT_OVER_TAU_SHIFT = adex_pkg::DT_OVER_TAU_SHIFT_DEF,
  parameter int unsigned EXP_TABLE_BITS    = adex_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  adex_pkg::cfg_t     cfg_i,
  input  adex_pkg::cmd_t     cmd_i,
  output adex_pkg::status_t  status_o,
  input  logic signed [31:0] cur_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] membrane_o,
  output logic signed [31:0] adaptation_o,
  output logic               spiked_o
);
  import adex_pkg::*;

  localparam int unsigned LOWB  = 16 - EXP_TABLE_BITS;
  localparam int unsigned TBL_N = (1 << EXP_TABLE_BITS) + 1;

  logic signed [31:0] v_q, w_q, cur_q, x1_q;
  logic               spk_q, neg_q;
  logic [DIV_W-1:0]   num_q, quo_q;
  logic [30:0]        rem_q;
  logic [5:0]         cnt_q;
  logic signed [67:0] prod_q;
  logic [17:0]        y0_q;
  logic signed [5:0]  n_q;
  logic [32:0]        ex_q;
  logic signed [31:0] expt_q, leak_q;
  logic               ov_q;
  logic signed [31:0] mo_q, ao_q;
  logic               so_q;

  logic [17:0] tbl [TBL_N];

  always_comb begin
    for (int i = 0; i < TBL_N; i++) begin
      tbl[i] = pow2_poly(17'(i << LOWB));
    end
  end

  logic [30:0]        dt;
  logic signed [31:0] dvt, x1_n;
  logic [31:0]        dvt_mag;
  logic [31:0]        rem_sh;
  logic [31:0]        rem_sub;
  logic signed [20:0] u;
  logic signed [21:0] t;
  logic [15:0]        f;
  logic [EXP_TABLE_BITS-1:0] addr;
  logic [EXP_TABLE_BITS:0]   addr1;
  logic [17:0]        y1;
  logic [17:0]        y;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [31:0] qp;
  logic signed [31:0] dv, dw, v_n, w_n;

  assign dt      = (cfg_i.slope_factor == '0) ? 31'd1 : cfg_i.slope_factor;
  assign dvt     = sat35(35'(v_q) - 35'(cfg_i.v_thresh));
  assign x1_n    = sat35(35'(v_q) - 35'(cfg_i.e_leak));
  assign dvt_mag = dvt[31] ? 32'(-33'(dvt)) : 32'(dvt);
  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dt};

  always_comb begin
    if (neg_q) begin
      u = (quo_q > U_MIN_MAG) ? -21'sd786432 : 21'(-49'(quo_q));
    end else begin
      u = (quo_q > U_MAX_MAG) ? 21'sd655360 : 21'(quo_q);
    end
  end

  assign t     = 22'(prod_q >>> 16);
  assign f     = t[15:0];
  assign addr  = f[15 -: EXP_TABLE_BITS];
  assign addr1 = {1'b0, addr} + 1'b1;
  assign y1    = tbl[addr1];
  assign y     = y0_q + 18'(prod_q >> LOWB);
  assign qp    = qsat(prod_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_LOG2E: begin
        ma = 34'(u);
        mb = LOG2E_Q;
      end
      OP_INTERP: begin
        ma = 34'(y1 - tbl[addr]);
        mb = 34'(f[LOWB-1:0]);
      end
      OP_MEXG: begin
        ma = {1'b0, ex_q};
        mb = 34'(cfg_i.g_leak);
      end
      OP_MEXD: begin
        ma = 34'(qp);
        mb = {3'b000, dt};
      end
      OP_MLEAK: begin
        ma = 34'(x1_q);
        mb = 34'(cfg_i.g_leak);
      end
      OP_MADAPT: begin
        ma = 34'(x1_q);
        mb = 34'(cfg_i.adapt_a);
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    dv  = sat35(35'(cur_q) - 35'(w_q) - 35'(leak_q) + 35'(expt_q));
    dw  = sat35(35'(qp) - 35'(w_q));
    if (spk_q) begin
      v_n = cfg_i.v_reset;
      w_n = sat35(35'(w_q) + 35'(cfg_i.adapt_b));
    end else begin
      v_n = sat35(35'(v_q) + 35'(dv >>> DT_OVER_C_SHIFT));
      w_n = sat35(35'(w_q) + 35'(dw >>> DT_OVER_TAU_SHIFT));
      if (v_n > cfg_i.v_peak) v_n = cfg_i.v_peak;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_q <= cur_i;
        x1_q  <= x1_n;
        neg_q <= dvt[31];
        num_q <= {dvt_mag, 16'h0000};
        quo_q <= '0;
        rem_q <= '0;
      end
      OP_DIV: begin
        num_q <= num_q << 1;
        if (rem_sh >= {1'b0, dt}) begin
          rem_q <= rem_sub[30:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[30:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
      end
      OP_LOG2E: prod_q <= prod;
      OP_INTERP: begin
        prod_q <= prod;
        y0_q   <= tbl[addr];
        n_q    <= t[21:16];
      end
      OP_SHIFT: begin
        if (!n_q[5]) ex_q <= 33'(y) << n_q;
        else ex_q <= 33'(y) >> 6'(-n_q);
      end
      OP_MEXG: prod_q <= prod;
      OP_MEXD: prod_q <= prod;
      OP_MLEAK: begin
        expt_q <= qp;
        prod_q <= prod;
      end
      OP_MADAPT: begin
        leak_q <= qp;
        prod_q <= prod;
      end
      default: ;
    endcase
  end

  // divider bit count and spike flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      spk_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      cnt_q <= '0;
      spk_q <= (v_q >= cfg_i.v_peak);
    end else if (cmd_i.op == OP_DIV) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= V_RESET_RST;
      w_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_UPDATE) begin
        v_q  <= v_n;
        w_q  <= w_n;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_UPDATE) begin
      mo_q <= v_n;
      ao_q <= w_n;
      so_q <= spk_q;
    end
  end

  assign status_o.div_done = (cnt_q == 6'(DIV_W - 1));
  assign status_o.spike    = spk_q;
  assign status_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o  = ov_q;
  assign membrane_o   = mo_q;
  assign adaptation_o = ao_q;
  assign spiked_o     = so_q;
endmodule

// ===== sv/adex_neuron_euler_step.sv =====
// top level: adaptive exponential integrate-and-fire neuron, one euler tick per item
// Each input item carries one current sample and yields one result item with the new
// membrane voltage and adaptation current, both signed Q16.16, and a spike flag. An
// accepted item whose stored voltage is at or above v_peak goes straight to the update
// (spike reset). Otherwise the item is taken, a 48-bit bit-serial divider forms
// (V-VT)/dT for the exponential, three steps form the exponential (log2(e) scaling,
// table lookup with interpolation, shift), four steps form the product terms and one
// updates; six passes in all go through one shared 34x34 multiplier. A new item is
// taken once the previous one has been written to the output register; a result
// waiting there delays only the next update.
// Registers sit on an APB port at byte address 4*index.
module adex_neuron_euler_step #(
  parameter int unsigned DT_OVER_C_SHIFT   = adex_pkg::DT_OVER_C_SHIFT_DEF,
  parameter int unsigned DT_OVER_TAU_SHIFT = adex_pkg::DT_OVER_TAU_SHIFT_DEF,
  parameter int unsigned EXP_TABLE_BITS    = adex_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  adex_in_if.sink                     in_if,
  adex_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adex_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import adex_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  adex_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adex_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adex_dp #(
    .DT_OVER_C_SHIFT   (DT_OVER_C_SHIFT),
    .DT_OVER_TAU_SHIFT (DT_OVER_TAU_SHIFT),
    .EXP_TABLE_BITS    (EXP_TABLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .cur_i        (in_if.injected_current),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .membrane_o   (out_if.membrane_out),
    .adaptation_o (out_if.adaptation_out),
    .spiked_o     (out_if.spiked)
  );
endmodule

// ===== tb/adex_neuron_euler_step_tb.sv =====
// testbench: adex neuron euler step checked item by item against a local fixed-point predictor
module adex_neuron_euler_step_tb;
  import adex_pkg::*;

  typedef struct packed {
    logic signed [31:0] membrane;
    logic signed [31:0] adaptation;
    logic               spiked;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  adex_in_if  cur_if ();
  adex_out_if tick_if ();

  adex_neuron_euler_step i_dut (
    .clk_i, .rst_ni, .in_if(cur_if.sink), .out_if(tick_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  longint m_gl, m_el, m_dt, m_vt, m_a, m_vr, m_b, m_vp, m_v, m_w;
  tick_t tick_q[$];
  int n_fail = 0;
  int stall_mode = 0;

  initial begin
    cur_if.valid = 1'b0;
    cur_if.injected_current = '0;
    tick_if.ready = 1'b0;
  end

  function automatic longint sx(logic [31:0] x);
    return longint'(signed'(x));
  endfunction

  function automatic longint fl_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qprod(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> 16;
    if (p > 128'sd2147483647) return 64'sd2147483647;
    if (p < -128'sd2147483648) return -64'sd2147483648;
    return longint'(p);
  endfunction

  function automatic longint poly2(longint x);
    longint t;
    t = 5155;
    t = 14822 + ((t * x) >> 16);
    t = 45559 + ((t * x) >> 16);
    return 65536 + ((t * x) >> 16);
  endfunction

  function automatic longint exp2e(longint u);
    int lb;
    longint t, n, f, ad, lo, y0, y1, y;
    lb = 16 - EXP_TABLE_BITS_DEF;
    if (u > 10 * 65536) u = 10 * 65536;
    if (u < -12 * 65536) u = -12 * 65536;
    t = fl_shr(u * 94548, 16);
    n = fl_shr(t, 16);
    f = t - n * 65536;
    ad = f >> lb;
    lo = f & ((64'd1 << lb) - 1);
    y0 = poly2(ad << lb);
    y1 = poly2((ad + 1) << lb);
    y = y0 + (((y1 - y0) * lo) >>> lb);
    if (n >= 0) return y << n;
    return y >> (-n);
  endfunction

  function automatic tick_t euler_tick(longint cur);
    tick_t r;
    longint dt, x1, dvt, u, ex, et, lk, dv, dw;
    r.spiked = 1'b0;
    if (m_v >= m_vp) begin
      m_v = m_vr;
      m_w = clip32(m_w + m_b);
      r.spiked = 1'b1;
    end else begin
      dt = (m_dt > 0) ? m_dt : 1;
      x1 = clip32(m_v - m_el);
      dvt = clip32(m_v - m_vt);
      u = (dvt * 65536) / dt;
      ex = exp2e(u);
      et = qprod(qprod(ex, m_gl), dt);
      lk = qprod(x1, m_gl);
      dv = clip32(cur - m_w - lk + et);
      dw = clip32(qprod(x1, m_a) - m_w);
      m_v = clip32(m_v + fl_shr(dv, DT_OVER_C_SHIFT_DEF));
      m_w = clip32(m_w + fl_shr(dw, DT_OVER_TAU_SHIFT_DEF));
      if (m_v > m_vp) m_v = m_vp;
    end
    r.membrane = m_v[31:0];
    r.adaptation = m_w[31:0];
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_G_LEAK:   m_gl = sx(val);
      REG_E_LEAK:   m_el = sx(val);
      REG_SLOPE:    m_dt = longint'(val[30:0]);
      REG_V_THRESH: m_vt = sx(val);
      REG_ADAPT_A:  m_a = sx(val);
      REG_V_RESET:  m_vr = sx(val);
      REG_ADAPT_B:  m_b = sx(val);
      default:      m_vp = sx(val);
    endcase
  endtask

  // push one current sample; gap cycles before it
  task automatic send_current(logic [31:0] cur, int gap);
    repeat (gap) begin
      @(posedge clk_i);
      cur_if.valid <= 1'b0;
    end
    @(posedge clk_i);
    cur_if.valid <= 1'b1;
    cur_if.injected_current <= cur;
    do @(posedge clk_i); while (!cur_if.ready);
    tick_q.push_back(euler_tick(sx(cur)));
    cur_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        if (tick_q.size() == 0) begin
          $error("unexpected result item");
          n_fail++;
        end else begin
          tick_t e;
          e = tick_q.pop_front();
          if (tick_if.membrane_out !== e.membrane) begin
            $error("membrane_out exp %0d got %0d", e.membrane, tick_if.membrane_out);
            n_fail++;
          end
          if (tick_if.adaptation_out !== e.adaptation) begin
            $error("adaptation_out exp %0d got %0d", e.adaptation, tick_if.adaptation_out);
            n_fail++;
          end
          if (tick_if.spiked !== e.spiked) begin
            $error("spiked exp %0b got %0b", e.spiked, tick_if.spiked);
            n_fail++;
          end
        end
      end
      case (stall_mode)
        0: tick_if.ready <= 1'b1;
        1: tick_if.ready <= ($urandom_range(3) != 0);
        default: tick_if.ready <= ($urandom_range(9) < 3);
      endcase
    end
  end

  function automatic logic [31:0] rnd_current();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
      default: return 32'($signed($urandom_range(4 * 65536)) - 65536);
    endcase
  endfunction

  task automatic test_defaults();
    logic [31:0] edge_vals[6] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff,
                                  32'h00010000, 32'h55555555};
    foreach (edge_vals[i]) send_current(edge_vals[i], $urandom_range(2));
    repeat (10) send_current(32'h00100000, 0);
    drain();
  endtask

  task automatic test_special();
    reg_write(REG_SLOPE, 32'h0);
    repeat (4) send_current(32'h00200000, 1);
    drain();
    reg_write(REG_SLOPE, 32'h7fffffff);
    reg_write(REG_G_LEAK, 32'h7fffffff);
    reg_write(REG_ADAPT_A, 32'h80000000);
    reg_write(REG_ADAPT_B, 32'h7fffffff);
    send_current(32'h80000000, 0);
    send_current(32'h7fffffff, 0);
    drain();
    // peak below current voltage forces a spike reset next
    reg_write(REG_V_PEAK, 32'h80000000);
    reg_write(REG_V_RESET, 32'h7fffffff);
    reg_write(REG_E_LEAK, 32'h80000000);
    reg_write(REG_V_THRESH, 32'h7fffffff);
    repeat (3) send_current(32'h0, 0);
    drain();
  endtask

  task automatic load_profile(int k);
    case (k)
      0: begin
        reg_write(REG_G_LEAK, G_LEAK_RST); reg_write(REG_E_LEAK, E_LEAK_RST);
        reg_write(REG_SLOPE, 32'(SLOPE_RST)); reg_write(REG_V_THRESH, V_THRESH_RST);
        reg_write(REG_ADAPT_A, ADAPT_A_RST); reg_write(REG_V_RESET, V_RESET_RST);
        reg_write(REG_ADAPT_B, ADAPT_B_RST); reg_write(REG_V_PEAK, V_PEAK_RST);
      end
      1: begin
        reg_write(REG_G_LEAK, $urandom_range(4 * 65536));
        reg_write(REG_E_LEAK, 32'($signed($urandom_range(10 * 65536)) - 80 * 65536));
        reg_write(REG_SLOPE, $urandom_range(1, 4 * 65536));
        reg_write(REG_V_THRESH, 32'($signed($urandom_range(20 * 65536)) - 60 * 65536));
        reg_write(REG_ADAPT_A, $urandom_range(8 * 65536));
        reg_write(REG_V_RESET, 32'($signed($urandom_range(20 * 65536)) - 70 * 65536));
        reg_write(REG_ADAPT_B, $urandom_range(100 * 65536));
        reg_write(REG_V_PEAK, 32'($signed($urandom_range(40 * 65536)) - 20 * 65536));
      end
      default: begin
        reg_write(REG_G_LEAK, $urandom()); reg_write(REG_E_LEAK, $urandom());
        reg_write(REG_SLOPE, $urandom()); reg_write(REG_V_THRESH, $urandom());
        reg_write(REG_ADAPT_A, $urandom()); reg_write(REG_V_RESET, $urandom());
        reg_write(REG_ADAPT_B, $urandom()); reg_write(REG_V_PEAK, $urandom());
      end
    endcase
  endtask

  task automatic test_random();
    int sent, burst;
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      stall_mode = ph % 3;
      load_profile(ph % 4 == 3 ? 2 : (ph % 4 == 0 ? 0 : 1));
      for (int k = 0; k < 150; k += burst) begin
        burst = $urandom_range(1, 20);
        for (int j = 0; j < burst; j++) send_current(rnd_current(), 0);
        if ($urandom_range(9) == 0) while (tick_q.size() != 0) @(posedge clk_i);
        else repeat ($urandom_range(8)) @(posedge clk_i);
      end
      drain();
    end
  endtask

  initial begin
    m_gl = G_LEAK_RST; m_el = E_LEAK_RST; m_dt = longint'(SLOPE_RST);
    m_vt = V_THRESH_RST; m_a = ADAPT_A_RST; m_vr = V_RESET_RST;
    m_b = ADAPT_B_RST; m_vp = V_PEAK_RST; m_v = V_RESET_RST; m_w = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_special();
    test_random();
    if (n_fail == 0) $display("** adex_neuron_euler_step: PASSED **");
    else $display("** adex_neuron_euler_step: FAILED **");
    $finish;
  end

  initial begin
    #10000000;
    $display("** adex_neuron_euler_step: FAILED **");
    $finish;
  end
endmodule
